// File: design/wtcqs_pkg.sv
// Package with shared types, codes and defaults of the three-class queue scheduler.
`default_nettype none
package wtcqs_pkg;
	localparam int QueueDepth = 16;
	localparam int NumQueues = 3;
	localparam int KeyW = 31;
	localparam int ClsW = 8;
	localparam int PayW = 32;
	localparam int WgtW = 4;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 8;

	typedef enum logic [1:0] {
		REQ_ADD = 2'd0,
		REQ_SERVE = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_ADDED = 3'd0,
		ST_FULL = 3'd1,
		ST_SERVED = 3'd2,
		ST_EMPTY = 3'd3,
		ST_REMOVED = 3'd4,
		ST_NOT_FOUND = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		CFG_HIGH = 3'd0,
		CFG_MID = 3'd1,
		CFG_W0 = 3'd2,
		CFG_W1 = 3'd3,
		CFG_W2 = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic [KeyW-1:0] key;
		logic [ClsW-1:0] cls;
		logic [PayW-1:0] pay;
	} entry_t;

	// Control sent to every cell of one queue.
	typedef struct packed {
		logic push;
		logic shift;
	} cell_ctl_t;
endpackage
`default_nettype wire

// File: design/wtcqs_cell.sv
// One queue slot: holds an entry and can take a new one or its right neighbor's.
`default_nettype none
module wtcqs_cell
	import wtcqs_pkg::*;
(
	input wire logic clk,
	input wire cell_ctl_t ctl,
	input wire logic sel_push,
	input wire logic sel_shift,
	input wire entry_t push_entry,
	input wire entry_t next_entry,
	output entry_t entry
);
	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.push && sel_push) begin
			entry_q <= push_entry;
		end else if (ctl.shift && sel_shift) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;
endmodule
`default_nettype wire

// File: design/wtcqs_queue.sv
// One FIFO queue built as a row of cells with length counter; its cells are exposed for the key search.
`default_nettype none
module wtcqs_queue
	import wtcqs_pkg::*;
#(
	parameter int QUEUE_DEPTH = QueueDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cell_ctl_t ctl,
	input wire entry_t push_entry,
	input wire logic [$clog2(QUEUE_DEPTH+1)-1:0] shift_from,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] len,
	output entry_t head,
	output entry_t cells_out [QUEUE_DEPTH]
);
	localparam int LenW = $clog2(QUEUE_DEPTH + 1);
	logic [LenW-1:0] len_q;
	entry_t ent [QUEUE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (ctl.push) begin
			len_q <= len_q + LenW'(1);
		end else if (ctl.shift) begin
			len_q <= len_q - LenW'(1);
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t nxt;
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign nxt = ent[i];
		end else begin : g_mid
			assign nxt = ent[i+1];
		end
		wtcqs_cell u_cell (
			.clk(clk),
			.ctl(ctl),
			.sel_push(len_q == LenW'(i)),
			.sel_shift(LenW'(i) >= shift_from),
			.push_entry(push_entry),
			.next_entry(nxt),
			.entry(ent[i])
		);
		assign cells_out[i] = ent[i];
	end

	assign len = len_q;
	assign head = ent[0];
endmodule
`default_nettype wire

// File: design/weighted_three_class_queue_scheduler.sv
// Top level of the three-class weighted round-robin queue scheduler.
//
// Channel  | Direction | Signals
// in       | input     | in_valid, in_ready, req_type, entry_key, entry_class_value, entry_payload
// out      | output    | out_valid, out_ready, status, served_*
// cfg      | input     | cfg_we, cfg_idx, cfg_data
//
// Add and serve pass through the scan state once; remove runs the
// one-slot-per-cycle key scan over the cell row until the first matching key
// or, when no key matches, to the end of the queue length.
// All queue shifting happens in parallel across the cell row.
// Reset clears lengths and turn state and loads the default limits and weights; cells are not reset.
// A stalled result holds in the output register and blocks the next transaction.
`default_nettype none
module weighted_three_class_queue_scheduler
	import wtcqs_pkg::*;
#(
	parameter int QUEUE_DEPTH = QueueDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] req_type,
	input wire logic [KeyW-1:0] entry_key,
	input wire logic [ClsW-1:0] entry_class_value,
	input wire logic [PayW-1:0] entry_payload,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] status,
	output logic [KeyW-1:0] served_key,
	output logic [ClsW-1:0] served_class_value,
	output logic [PayW-1:0] served_payload,
	output logic [1:0] served_queue,
	input wire logic cfg_we,
	input wire logic [CfgIdxW-1:0] cfg_idx,
	input wire logic [CfgDataW-1:0] cfg_data
);
	localparam int LenW = $clog2(QUEUE_DEPTH + 1);
	localparam int PosW = $clog2(QUEUE_DEPTH);

	logic [ClsW-1:0] high_q, mid_q;
	logic [WgtW-1:0] wgt_q [NumQueues];
	logic [1:0] cur_q;
	logic [WgtW-1:0] cnt_q;
	fsm_t state_q, state_d;
	logic [1:0] req_q, q_sel_q;
	entry_t in_q;
	logic [LenW-1:0] pos_q;
	logic [2:0] st_q;
	entry_t out_ent_q;
	logic [1:0] out_qn_q;
	logic out_valid_q;

	cell_ctl_t ctl [NumQueues];
	logic [LenW-1:0] len [NumQueues];
	entry_t head [NumQueues];
	entry_t cells [NumQueues][QUEUE_DEPTH];
	logic [LenW-1:0] shift_from;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q <= 8'd55;
			mid_q <= 8'd40;
			wgt_q[0] <= 4'd3;
			wgt_q[1] <= 4'd1;
			wgt_q[2] <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_HIGH: high_q <= cfg_data;
				CFG_MID: mid_q <= cfg_data;
				CFG_W0: wgt_q[0] <= cfg_data[WgtW-1:0];
				CFG_W1: wgt_q[1] <= cfg_data[WgtW-1:0];
				CFG_W2: wgt_q[2] <= cfg_data[WgtW-1:0];
				default: ;
			endcase
		end
	end

	function automatic logic [1:0] nxt(input logic [1:0] q);
		nxt = (q == 2'd2) ? 2'd0 : q + 2'd1;
	endfunction

	// Serve selection.
	logic [1:0] sq0, sq;
	logic [WgtW-1:0] wcur;
	logic move;
	logic all_empty;
	always_comb begin
		wcur = (wgt_q[cur_q] == '0) ? WgtW'(1) : wgt_q[cur_q];
		move = (cnt_q >= wcur) || (len[cur_q] == '0);
		sq0 = move ? nxt(cur_q) : cur_q;
		sq = sq0;
		if (len[sq0] == '0) begin
			sq = nxt(sq0);
			if (len[nxt(sq0)] == '0) sq = nxt(nxt(sq0));
		end
		all_empty = (len[0] == '0) && (len[1] == '0) && (len[2] == '0);
	end

	logic [1:0] pick;
	assign pick = (entry_class_value > high_q) ? 2'd0 :
		(entry_class_value > mid_q) ? 2'd1 : 2'd2;

	entry_t scan_ent;
	assign scan_ent = cells[q_sel_q][pos_q[PosW-1:0]];

	logic accept;
	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign accept = in_valid && in_ready && (req_type != REQ_NONE);

	always_comb begin
		state_d = state_q;
		shift_from = pos_q;
		for (int k = 0; k < NumQueues; k++) ctl[k] = '0;
		case (state_q)
			S_IDLE: if (accept) state_d = S_SCAN;
			S_SCAN: begin
				state_d = S_DONE;
				case (req_q)
					REQ_ADD:
						if (len[q_sel_q] != LenW'(QUEUE_DEPTH)) ctl[q_sel_q].push = 1'b1;
					REQ_SERVE:
						if (!all_empty) begin
							ctl[sq].shift = 1'b1;
							shift_from = '0;
						end
					REQ_REMOVE:
						if (pos_q < len[q_sel_q]) begin
							if (scan_ent.key == in_q.key) ctl[q_sel_q].shift = 1'b1;
							else state_d = S_SCAN;
						end
					default: ;
				endcase
			end
			S_DONE: if (!out_valid_q || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			pos_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) pos_q <= '0;
			if (state_q == S_SCAN) begin
				case (req_q)
					REQ_SERVE:
						if (!all_empty) begin
							cur_q <= sq;
							cnt_q <= (sq != cur_q || move) ? WgtW'(1) : cnt_q + WgtW'(1);
						end
					REQ_REMOVE:
						if (state_d == S_SCAN) pos_q <= pos_q + LenW'(1);
					default: ;
				endcase
			end
			if (state_q == S_DONE && state_d == S_IDLE) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			q_sel_q <= pick;
			in_q <= '{key: entry_key, cls: entry_class_value, pay: entry_payload};
		end
		if (state_q == S_SCAN) begin
			if (req_q == REQ_SERVE && !all_empty) begin
				out_ent_q <= head[sq];
				out_qn_q <= sq;
			end else begin
				out_ent_q <= '0;
				out_qn_q <= '0;
			end
			case (req_q)
				REQ_ADD:
					st_q <= (len[q_sel_q] != LenW'(QUEUE_DEPTH)) ? ST_ADDED : ST_FULL;
				REQ_SERVE:
					st_q <= all_empty ? ST_EMPTY : ST_SERVED;
				default:
					st_q <= (pos_q < len[q_sel_q]) ? ST_REMOVED : ST_NOT_FOUND;
			endcase
		end
	end

	for (genvar g = 0; g < NumQueues; g++) begin : g_q
		wtcqs_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl[g]),
			.push_entry(in_q),
			.shift_from(shift_from),
			.len(len[g]),
			.head(head[g]),
			.cells_out(cells[g])
		);
	end

	assign out_valid = out_valid_q;
	assign status = st_q;
	assign served_key = out_ent_q.key;
	assign served_class_value = out_ent_q.cls;
	assign served_payload = out_ent_q.pay;
	assign served_queue = out_qn_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == S_IDLE)) else $error("ready outside idle");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(len[0] <= LenW'(QUEUE_DEPTH)) && (len[1] <= LenW'(QUEUE_DEPTH))
		&& (len[2] <= LenW'(QUEUE_DEPTH))) else $error("queue length overflow");
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({ctl[0].push, ctl[0].shift, ctl[1].push, ctl[1].shift,
		ctl[2].push, ctl[2].shift}) <= 1) else $error("multiple queue ops");
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q != 2'd3) else $error("bad current queue");
endmodule
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the three-class weighted round-robin queue scheduler.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import wtcqs_pkg::*;

	localparam int HoldOffCycles = 300;
	localparam int WatchdogLimit = 5000;

	typedef struct packed {
		logic [1:0] req;
		logic [KeyW-1:0] key;
		logic [ClsW-1:0] cls;
		logic [PayW-1:0] pay;
	} request_t;

	typedef struct packed {
		logic [2:0] status;
		logic [KeyW-1:0] key;
		logic [ClsW-1:0] cls;
		logic [PayW-1:0] pay;
		logic [1:0] queue;
	} reply_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] req_type;
	logic [KeyW-1:0] entry_key;
	logic [ClsW-1:0] entry_class_value;
	logic [PayW-1:0] entry_payload;
	logic out_valid;
	logic out_ready;
	logic [2:0] status;
	logic [KeyW-1:0] served_key;
	logic [ClsW-1:0] served_class_value;
	logic [PayW-1:0] served_payload;
	logic [1:0] served_queue;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_idx;
	logic [CfgDataW-1:0] cfg_data;

	weighted_three_class_queue_scheduler uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.entry_key(entry_key),
		.entry_class_value(entry_class_value),
		.entry_payload(entry_payload),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.served_key(served_key),
		.served_class_value(served_class_value),
		.served_payload(served_payload),
		.served_queue(served_queue),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// Scheduler image kept by the testbench.
	entry_t sched_entries[NumQueues][$];
	logic [1:0] sched_turn_queue;
	logic [3:0] sched_turn_count;
	logic [ClsW-1:0] sched_high_limit;
	logic [ClsW-1:0] sched_mid_limit;
	logic [WgtW-1:0] sched_weights[NumQueues];

	request_t pending_requests[$];
	reply_t expected_replies[$];
	int accepted_count;
	int reply_count;
	int failures;
	bit hold_off_request;
	int keys_in_use[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [1:0] class_to_queue(logic [ClsW-1:0] cls);
		if (cls > sched_high_limit)
			return 2'd0;
		if (cls > sched_mid_limit)
			return 2'd1;
		return 2'd2;
	endfunction

	function automatic int turn_weight(logic [1:0] q);
		return sched_weights[q] == 0 ? 1 : int'(sched_weights[q]);
	endfunction

	function automatic reply_t schedule_request(request_t r);
		reply_t rep;
		logic [1:0] q;
		int cnt;
		rep = '0;
		q = class_to_queue(r.cls);
		case (r.req)
			REQ_ADD: begin
				if (sched_entries[q].size() >= QueueDepth) begin
					rep.status = ST_FULL;
				end else begin
					sched_entries[q].push_back('{key: r.key, cls: r.cls, pay: r.pay});
					rep.status = ST_ADDED;
				end
			end
			REQ_SERVE: begin
				if (sched_entries[0].size() == 0 && sched_entries[1].size() == 0
						&& sched_entries[2].size() == 0) begin
					rep.status = ST_EMPTY;
				end else begin
					q = sched_turn_queue;
					cnt = int'(sched_turn_count);
					if (cnt >= turn_weight(q) || sched_entries[q].size() == 0) begin
						q = (q == 2) ? 2'd0 : q + 2'd1;
						cnt = 0;
					end
					while (sched_entries[q].size() == 0) begin
						q = (q == 2) ? 2'd0 : q + 2'd1;
						cnt = 0;
					end
					rep.status = ST_SERVED;
					rep.key = sched_entries[q][0].key;
					rep.cls = sched_entries[q][0].cls;
					rep.pay = sched_entries[q][0].pay;
					rep.queue = q;
					void'(sched_entries[q].pop_front());
					sched_turn_queue = q;
					sched_turn_count = 4'(cnt + 1);
				end
			end
			REQ_REMOVE: begin
				rep.status = ST_NOT_FOUND;
				foreach (sched_entries[q][i]) begin
					if (sched_entries[q][i].key == r.key) begin
						sched_entries[q].delete(i);
						rep.status = ST_REMOVED;
						break;
					end
				end
			end
			default: ;
		endcase
		return rep;
	endfunction

	// Driver.
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= REQ_ADD;
			entry_key <= '0;
			entry_class_value <= '0;
			entry_payload <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				accepted_count++;
				if (req_type != REQ_NONE)
					expected_replies.push_back(schedule_request({req_type, entry_key,
						entry_class_value, entry_payload}));
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0 || pending_requests.size() == 0) begin
					in_valid <= 1'b0;
					if (send_gap > 0)
						send_gap--;
				end else begin
					request_t r;
					r = pending_requests.pop_front();
					in_valid <= 1'b1;
					req_type <= r.req;
					entry_key <= r.key;
					entry_class_value <= r.cls;
					entry_payload <= r.pay;
					send_gap = $urandom_range(0, 7);
					if ($urandom_range(0, 3) == 0)
						send_gap = 0;
				end
			end
		end
	end

	// Monitor and receiver stalls.
	int recv_gap;
	int hold_off_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap = 0;
			hold_off_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				reply_t exp_rep;
				reply_count++;
				if (expected_replies.size() == 0) begin
					failures++;
					$display("%0t: unexpected transaction, actual status %0d", $time, status);
				end else begin
					exp_rep = expected_replies.pop_front();
					if (status != exp_rep.status) begin
						failures++;
						$display("%0t: status expected %0d actual %0d", $time,
							exp_rep.status, status);
					end
					if (served_key != exp_rep.key) begin
						failures++;
						$display("%0t: served_key expected %0h actual %0h", $time,
							exp_rep.key, served_key);
					end
					if (served_class_value != exp_rep.cls) begin
						failures++;
						$display("%0t: served_class_value expected %0d actual %0d", $time,
							exp_rep.cls, served_class_value);
					end
					if (served_payload != exp_rep.pay) begin
						failures++;
						$display("%0t: served_payload expected %0h actual %0h", $time,
							exp_rep.pay, served_payload);
					end
					if (served_queue != exp_rep.queue) begin
						failures++;
						$display("%0t: served_queue expected %0d actual %0d", $time,
							exp_rep.queue, served_queue);
					end
				end
			end
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				hold_off_left = HoldOffCycles;
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				out_ready <= 1'b0;
			end else if (out_valid && out_ready || !out_ready) begin
				if (recv_gap > 0) begin
					recv_gap--;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
					recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
				end
			end
		end
	end

	// Watchdog on cycles without any transaction.
	int idle_cycles;
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| hold_off_left > 0) begin
			idle_cycles <= 0;
		end else if (pending_requests.size() != 0 || expected_replies.size() != 0
				|| in_valid) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WatchdogLimit) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	function automatic request_t make_request(logic [1:0] req, logic [KeyW-1:0] key,
			logic [ClsW-1:0] cls, logic [PayW-1:0] pay);
		request_t r;
		r.req = req;
		r.key = key;
		r.cls = cls;
		r.pay = pay;
		return r;
	endfunction

	function automatic logic [KeyW-1:0] random_key();
		return KeyW'({$urandom(), $urandom()} >> 33);
	endfunction

	task automatic wait_drained();
		while (pending_requests.size() != 0 || in_valid || expected_replies.size() != 0)
			@(posedge clk);
		repeat (QueueDepth + 4) @(posedge clk);
	endtask

	task automatic write_register(cfg_idx_t idx, logic [CfgDataW-1:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_HIGH: sched_high_limit = value;
			CFG_MID: sched_mid_limit = value;
			CFG_W0: sched_weights[0] = value[WgtW-1:0];
			CFG_W1: sched_weights[1] = value[WgtW-1:0];
			CFG_W2: sched_weights[2] = value[WgtW-1:0];
			default: ;
		endcase
	endtask

	// Mostly well-formed traffic: adds with fresh keys, serves, and removes of live keys.
	task automatic queue_random_traffic(int count);
		logic [KeyW-1:0] k;
		int pick;
		int idx;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			k = random_key();
			if (pick < 45) begin
				pending_requests.push_back(make_request(REQ_ADD, k, ClsW'($urandom()),
					$urandom()));
				keys_in_use.push_back(int'(k));
			end else if (pick < 75) begin
				pending_requests.push_back(make_request(REQ_SERVE, k, ClsW'($urandom()),
					$urandom()));
			end else if (pick < 92 && keys_in_use.size() != 0) begin
				idx = $urandom_range(0, keys_in_use.size() - 1);
				pending_requests.push_back(make_request(REQ_REMOVE, KeyW'(keys_in_use[idx]),
					ClsW'($urandom()), $urandom()));
				keys_in_use.delete(idx);
			end else if (pick < 97) begin
				pending_requests.push_back(make_request(REQ_REMOVE, k, ClsW'($urandom()),
					$urandom()));
			end else begin
				pending_requests.push_back(make_request(REQ_NONE, k, ClsW'($urandom()),
					$urandom()));
			end
			if (keys_in_use.size() > 64)
				keys_in_use.delete(0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_HIGH;
		cfg_data = '0;
		failures = 0;
		accepted_count = 0;
		reply_count = 0;
		hold_off_request = 1'b0;
		sched_turn_queue = 2'd0;
		sched_turn_count = 4'd0;
		sched_high_limit = 8'd55;
		sched_mid_limit = 8'd40;
		sched_weights[0] = 4'd3;
		sched_weights[1] = 4'd1;
		sched_weights[2] = 4'd1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under reset defaults.
		pending_requests.push_back(make_request(REQ_SERVE, '0, '0, '0));
		pending_requests.push_back(make_request(REQ_ADD, '1, 8'd255, '1));
		pending_requests.push_back(make_request(REQ_ADD, '0, 8'd0, '0));
		pending_requests.push_back(make_request(REQ_ADD, 31'h2AAAAAAA, 8'd55, 32'hA5A5A5A5));
		pending_requests.push_back(make_request(REQ_ADD, 31'h55555555, 8'd56, 32'h5A5A5A5A));
		pending_requests.push_back(make_request(REQ_ADD, 31'd7, 8'd41, 32'd7));
		pending_requests.push_back(make_request(REQ_ADD, 31'd8, 8'd40, 32'd8));
		pending_requests.push_back(make_request(REQ_NONE, 31'd9, 8'd200, 32'd9));
		pending_requests.push_back(make_request(REQ_REMOVE, 31'd8, 8'd0, '0));
		pending_requests.push_back(make_request(REQ_REMOVE, 31'd8, 8'd0, '0));
		pending_requests.push_back(make_request(REQ_REMOVE, 31'd7, 8'd255, '0));
		for (int i = 0; i < 17; i++)
			pending_requests.push_back(make_request(REQ_ADD, 31'(100 + i), 8'd10, 32'(i)));
		for (int i = 0; i < 8; i++)
			pending_requests.push_back(make_request(REQ_SERVE, '0, '0, '0));
		wait_drained();

		// Long receiver stall while the sender keeps offering.
		hold_off_request = 1'b1;
		queue_random_traffic(60);
		wait_drained();

		write_register(CFG_HIGH, 8'd255);
		write_register(CFG_MID, 8'd0);
		write_register(CFG_W0, 8'd15);
		write_register(CFG_W1, 8'd0);
		write_register(CFG_W2, 8'd15);
		queue_random_traffic(160);
		wait_drained();

		write_register(CFG_HIGH, 8'd0);
		write_register(CFG_MID, 8'd255);
		write_register(CFG_W0, 8'd1);
		write_register(CFG_W1, 8'd15);
		write_register(CFG_W2, 8'd1);
		queue_random_traffic(160);
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			write_register(CFG_HIGH, 8'($urandom_range(100, 255)));
			write_register(CFG_MID, 8'($urandom_range(0, 99)));
			write_register(CFG_W0, 8'($urandom_range(1, 15)));
			write_register(CFG_W1, 8'($urandom_range(1, 15)));
			write_register(CFG_W2, 8'($urandom_range(1, 15)));
			queue_random_traffic(110);
			wait_drained();
		end

		if (failures == 0 && expected_replies.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire

// File: weighted_three_class_queue_scheduler.f
design/wtcqs_pkg.sv
design/wtcqs_cell.sv
design/wtcqs_queue.sv
design/weighted_three_class_queue_scheduler.sv
test/testbench.sv
